/* src/fbfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and codes of the fixed-size block pool with a free list.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int CMD_W      = 2;
  localparam int BYTES_W    = 16;
  localparam int HANDLE_W   = 10;
  localparam int PRE_W      = 24;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 11;
  localparam int PAGES_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [BYTES_W-1:0] PTR_BYTES = 16'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PREALLOC = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_MEMORY = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NULL_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_HANDLE = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_GROW   = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [BYTES_W-1:0]  request_bytes;
    logic                handle_present;
    logic [HANDLE_W-1:0] free_handle;
    logic [PRE_W-1:0]    prealloc_bytes;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted_handle;
    logic [COUNT_W-1:0]  live_count;
    logic [COUNT_W-1:0]  peak_count;
    logic [PAGES_W-1:0]  pages_in_use;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pre_init;
    logic pre_step;
    logic sweep_step;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_pre;
    logic op_alloc;
    logic grow_needed;
    logic room;
    logic pre_more;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

/* src/fixed_block_free_list_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block pool: allocate, free, preallocate and release-all on a
// singly linked free list kept in one link RAM.
// ----------------------------------------------------------------------------
// Allocate from a non-empty list, free and release-all are accepted, then
// executed with the result registered. An allocate that must link a new
// page and preallocate run page link sweeps, in which a page is linked one
// block per cycle through the single write port of the link RAM. The next
// transaction is taken while a result still waits in the output register.
// The link RAM needs no clearing after reset: an entry is read only after it
// has been written.
module fixed_block_free_list_allocator #(
  parameter int BLOCKS_PER_BUBBLE = 128,
  parameter int MAX_BUBBLES       = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fbfl_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fbfl_pkg::out_item_t             out_data,
  input  logic                            cfg_write,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data
);

  fbfl_pkg::ctrl_cmd_t  cmd;
  fbfl_pkg::dp_status_t st;

  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  fbfl_datapath #(
    .BLOCKS_PER_BUBBLE (BLOCKS_PER_BUBBLE),
    .MAX_BUBBLES       (MAX_BUBBLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* src/fbfl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/fbfl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Sequencer of the block pool: accepts a transaction, runs page link sweeps
// and preallocate steps, and commits the result.
// ----------------------------------------------------------------------------
module fbfl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  fbfl_pkg::dp_status_t   st,
  output fbfl_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PRE_MUL,
    S_PRE_NEXT,
    S_SWEEP,
    S_RD_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          state_next = st.in_is_pre ? S_PRE_MUL : S_EXEC;
        end
      end
      S_PRE_MUL: begin
        cmd.pre_init = 1'b1;
        state_next   = st.room ? S_SWEEP : S_EXEC;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) begin
          state_next = st.op_alloc ? S_RD_WAIT : S_PRE_NEXT;
        end
      end
      S_PRE_NEXT: begin
        if (st.pre_more) begin
          cmd.pre_step = 1'b1;
          state_next   = S_SWEEP;
        end else begin
          state_next = S_EXEC;
        end
      end
      // link memory read of the new head lands next cycle
      S_RD_WAIT: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (st.grow_needed) begin
          state_next = S_SWEEP;
        end else if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

  a_sweep_needs_room: assert property (@(posedge clk) disable iff (rst)
    (state != S_SWEEP && state_next == S_SWEEP) |-> st.room)
    else $error("page sweep started with all pages in use");

  a_sweep_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && st.sweep_last) |=> (state == S_RD_WAIT || state == S_PRE_NEXT))
    else $error("page sweep did not hand over after its last link");

endmodule

/* src/fbfl_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_datapath
// Free list state, link memory, page sweep counter, preallocate countdown and
// the result register.
// ----------------------------------------------------------------------------
module fbfl_datapath #(
  parameter int BLOCKS_PER_BUBBLE = 128,
  parameter int MAX_BUBBLES       = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fbfl_pkg::in_item_t                  in_data,
  input  logic                                cfg_write,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fbfl_pkg::ctrl_cmd_t                 cmd,
  output fbfl_pkg::dp_status_t                st,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fbfl_pkg::out_item_t                 out_data
);

  localparam int TOTAL  = BLOCKS_PER_BUBBLE * MAX_BUBBLES;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int LINK_W = ADDR_W + 1;
  localparam int PAGE_W = $clog2(MAX_BUBBLES + 1);
  localparam int JW     = $clog2(BLOCKS_PER_BUBBLE);
  localparam int LIM_W  = ADDR_W + 1;
  localparam int CMP_W  = (LIM_W > fbfl_pkg::HANDLE_W) ? LIM_W : fbfl_pkg::HANDLE_W;
  localparam int PB_W   = JW + fbfl_pkg::BYTES_W;
  localparam int REM_W  = (PB_W > fbfl_pkg::PRE_W) ? PB_W : fbfl_pkg::PRE_W;

  fbfl_pkg::in_item_t op;

  logic [fbfl_pkg::BYTES_W-1:0] block_bytes;
  logic                         auto_grow;
  logic [ADDR_W-1:0]            head;
  logic                         empty;
  logic [PAGE_W-1:0]            page_count;
  logic [fbfl_pkg::COUNT_W-1:0] live;
  logic [fbfl_pkg::COUNT_W-1:0] peak;
  logic [JW-1:0]                j;
  logic [PB_W-1:0]              pb;
  logic [REM_W-1:0]             rem;

  logic [fbfl_pkg::BYTES_W-1:0] eff_bytes;
  logic                         too_large;
  logic                         room;
  logic [LIM_W-1:0]             base_full;
  logic [ADDR_W-1:0]            base;
  logic [CMP_W-1:0]             handle_ext;
  logic                         bad_handle;
  logic [ADDR_W-1:0]            handle_addr;
  logic                         free_ok;
  logic [ADDR_W-1:0]            sweep_addr;
  logic                         sweep_last;
  logic [LINK_W-1:0]            sweep_word;
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [LINK_W-1:0]            ram_wdata;
  logic [LINK_W-1:0]            link_rd;

  logic [ADDR_W-1:0]              head_next;
  logic                           empty_next;
  logic [PAGE_W-1:0]              page_count_next;
  logic [fbfl_pkg::COUNT_W-1:0]   live_next;
  logic [fbfl_pkg::COUNT_W-1:0]   peak_next;
  logic [fbfl_pkg::STATUS_W-1:0]  res_status;
  logic [fbfl_pkg::HANDLE_W-1:0]  res_grant;

  assign eff_bytes   = (block_bytes < fbfl_pkg::PTR_BYTES) ? fbfl_pkg::PTR_BYTES : block_bytes;
  assign too_large   = (op.request_bytes > eff_bytes);
  assign room        = (page_count < PAGE_W'(MAX_BUBBLES));
  assign base_full   = LIM_W'(page_count) * LIM_W'(BLOCKS_PER_BUBBLE);
  assign base        = base_full[ADDR_W-1:0];
  assign handle_ext  = CMP_W'(op.free_handle);
  assign bad_handle  = (handle_ext >= CMP_W'(base_full));
  assign handle_addr = handle_ext[ADDR_W-1:0];
  assign free_ok     = (op.command == fbfl_pkg::CMD_FREE) && op.handle_present && !bad_handle;

  // new page: ascending links, last block points at the old list
  assign sweep_addr = base + ADDR_W'(j);
  assign sweep_last = (j == JW'(BLOCKS_PER_BUBBLE - 1));
  assign sweep_word = sweep_last ? {empty, head} : {1'b0, sweep_addr + ADDR_W'(1)};

  assign ram_we    = cmd.sweep_step || (cmd.commit && free_ok);
  assign ram_waddr = cmd.sweep_step ? sweep_addr : handle_addr;
  assign ram_wdata = cmd.sweep_step ? sweep_word : {empty, head};

  fbfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TOTAL)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head),
    .rdata (link_rd)
  );

  always_comb begin
    head_next       = head;
    empty_next      = empty;
    page_count_next = page_count;
    live_next       = live;
    res_status      = fbfl_pkg::STAT_OK;
    res_grant       = '0;
    case (op.command)
      fbfl_pkg::CMD_ALLOC: begin
        if (too_large) begin
          res_status = fbfl_pkg::STAT_TOO_LARGE;
        end else if (empty) begin
          res_status = fbfl_pkg::STAT_NO_MEMORY;
        end else begin
          res_grant  = fbfl_pkg::HANDLE_W'(head);
          head_next  = link_rd[ADDR_W-1:0];
          empty_next = link_rd[ADDR_W];
          live_next  = (live == fbfl_pkg::COUNT_MAX) ? live
                                                     : live + fbfl_pkg::COUNT_W'(1);
        end
      end
      fbfl_pkg::CMD_FREE: begin
        if (!op.handle_present) begin
          res_status = fbfl_pkg::STAT_NULL_FREE;
        end else if (bad_handle) begin
          res_status = fbfl_pkg::STAT_BAD_HANDLE;
        end else begin
          head_next  = handle_addr;
          empty_next = 1'b0;
          live_next  = (live != '0) ? live - fbfl_pkg::COUNT_W'(1) : live;
        end
      end
      fbfl_pkg::CMD_RELEASE: begin
        head_next       = '0;
        empty_next      = 1'b1;
        page_count_next = '0;
        live_next       = '0;
      end
      default: begin
      end
    endcase
    peak_next = (live_next > peak) ? live_next : peak;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= fbfl_pkg::PTR_BYTES;
      auto_grow   <= 1'b1;
      head        <= '0;
      empty       <= 1'b1;
      page_count  <= '0;
      live        <= '0;
      peak        <= '0;
      j           <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          fbfl_pkg::REG_BLOCK_BYTES: block_bytes <= cfg_data;
          fbfl_pkg::REG_AUTO_GROW:   auto_grow   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.sweep_step) begin
        if (sweep_last) begin
          j          <= '0;
          head       <= base;
          empty      <= 1'b0;
          page_count <= page_count + PAGE_W'(1);
        end else begin
          j <= j + JW'(1);
        end
      end
      if (cmd.commit) begin
        head       <= head_next;
        empty      <= empty_next;
        page_count <= page_count_next;
        live       <= live_next;
        peak       <= peak_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_data;
    end
    if (cmd.pre_init) begin
      pb  <= PB_W'(eff_bytes) * PB_W'(BLOCKS_PER_BUBBLE);
      rem <= REM_W'(op.prealloc_bytes);
    end else if (cmd.pre_step) begin
      rem <= rem - REM_W'(pb);
    end
    if (cmd.commit) begin
      out_data.status         <= res_status;
      out_data.granted_handle <= res_grant;
      out_data.live_count     <= live_next;
      out_data.peak_count     <= peak_next;
      out_data.pages_in_use   <= fbfl_pkg::PAGES_W'(page_count_next);
    end
  end

  assign st.in_is_pre   = (in_data.command == fbfl_pkg::CMD_PREALLOC);
  assign st.op_alloc    = (op.command == fbfl_pkg::CMD_ALLOC);
  assign st.grow_needed = st.op_alloc && !too_large && empty && auto_grow && room;
  assign st.room        = room;
  assign st.pre_more    = room && (rem >= REM_W'(pb));
  assign st.sweep_last  = sweep_last;
  assign st.out_free    = !out_valid || !out_stall;

  a_page_added: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep_step && sweep_last) |=> page_count == $past(page_count) + PAGE_W'(1))
    else $error("page count not advanced after page sweep");

  a_free_push: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && free_ok) |=> (!empty && head == $past(handle_addr)))
    else $error("freed handle not at list head");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed transaction has no result");

endmodule

/* bench/fixed_block_free_list_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_tb
// Self-checking bench for the block pool. Commands go in through the
// valid/stall input channel while a pool model in the bench keeps its own
// free list, page count and live/peak counters. Every transaction on the
// result channel is checked field by field against the model. Directed
// corner cases come first, then random traffic built mostly from
// allocate/free pairs over several register settings.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_tb;

  localparam int BLOCKS    = 128;
  localparam int MAX_PAGES = 8;
  localparam int POOL_SIZE = BLOCKS * MAX_PAGES;
  localparam int IN_W      = $bits(fbfl_pkg::in_item_t);

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  fbfl_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  fbfl_pkg::out_item_t             out_data;
  logic                            cfg_write = 1'b0;
  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index = fbfl_pkg::REG_BLOCK_BYTES;
  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // pool model
  int unsigned link_mem [POOL_SIZE];
  bit          link_end [POOL_SIZE];
  int unsigned head = 0;
  bit          list_empty = 1'b1;
  int unsigned pages = 0;
  int unsigned live = 0;
  int unsigned peak = 0;
  int unsigned blk_bytes = 8;
  bit          grow_en = 1'b1;

  fbfl_pkg::out_item_t pending_results [$];
  fbfl_pkg::out_item_t last_result;
  int unsigned         held_handles [$];
  int                  errors = 0;
  bit                  in_idle = 1'b1;
  bit                  out_idle = 1'b1;
  int                  stall_left = 0;

  fixed_block_free_list_allocator #(
    .BLOCKS_PER_BUBBLE(BLOCKS),
    .MAX_BUBBLES(MAX_PAGES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned eff_block_bytes();
    return (blk_bytes < 32'(fbfl_pkg::PTR_BYTES)) ? 32'(fbfl_pkg::PTR_BYTES) : blk_bytes;
  endfunction

  // new page: blocks linked in ascending order, then the old list
  function automatic void link_page();
    int unsigned base;
    if (pages >= MAX_PAGES) return;
    base = pages * BLOCKS;
    for (int j = 0; j < BLOCKS - 1; j++) begin
      link_mem[base + j] = base + j + 1;
      link_end[base + j] = 1'b0;
    end
    link_mem[base + BLOCKS - 1] = head;
    link_end[base + BLOCKS - 1] = list_empty;
    head = base;
    list_empty = 1'b0;
    pages++;
  endfunction

  function automatic fbfl_pkg::out_item_t pool_step(fbfl_pkg::in_item_t it);
    fbfl_pkg::out_item_t r;
    int unsigned         n;
    r = '0;
    r.status = fbfl_pkg::STAT_OK;
    case (it.command)
      fbfl_pkg::CMD_ALLOC: begin
        if (it.request_bytes > eff_block_bytes()) begin
          r.status = fbfl_pkg::STAT_TOO_LARGE;
        end else begin
          if (list_empty && grow_en) link_page();
          if (list_empty) begin
            r.status = fbfl_pkg::STAT_NO_MEMORY;
          end else begin
            r.granted_handle = fbfl_pkg::HANDLE_W'(head);
            list_empty = link_end[head];
            head = link_mem[head];
            if (live < fbfl_pkg::COUNT_MAX) live++;
            if (live > peak) peak = live;
          end
        end
      end
      fbfl_pkg::CMD_FREE: begin
        if (!it.handle_present) begin
          r.status = fbfl_pkg::STAT_NULL_FREE;
        end else if (it.free_handle >= pages * BLOCKS) begin
          r.status = fbfl_pkg::STAT_BAD_HANDLE;
        end else begin
          link_mem[it.free_handle] = head;
          link_end[it.free_handle] = list_empty;
          head = 32'(it.free_handle);
          list_empty = 1'b0;
          if (live > 0) live--;
        end
      end
      fbfl_pkg::CMD_PREALLOC: begin
        n = it.prealloc_bytes / (BLOCKS * eff_block_bytes()) + 1;
        if (n > MAX_PAGES) n = MAX_PAGES;
        for (int i = 0; i < n; i++) link_page();
      end
      default: begin
        head = 0;
        list_empty = 1'b1;
        pages = 0;
        live = 0;
      end
    endcase
    r.live_count = fbfl_pkg::COUNT_W'(live);
    r.peak_count = fbfl_pkg::COUNT_W'(peak);
    r.pages_in_use = fbfl_pkg::PAGES_W'(pages);
    return r;
  endfunction

  function automatic fbfl_pkg::in_item_t make_item(logic [fbfl_pkg::CMD_W-1:0] cmd,
                                                   int unsigned req, bit present,
                                                   int unsigned hnd, int unsigned pre);
    fbfl_pkg::in_item_t it;
    it.command = cmd;
    it.request_bytes = fbfl_pkg::BYTES_W'(req);
    it.handle_present = present;
    it.free_handle = fbfl_pkg::HANDLE_W'(hnd);
    it.prealloc_bytes = fbfl_pkg::PRE_W'(pre);
    return it;
  endfunction

  // called right after a rising edge; leaves valid high for a following item
  task automatic send_item(fbfl_pkg::in_item_t it);
    int gap;
    gap = in_idle ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    last_result = pool_step(it);
    pending_results.insert(pending_results.size(), last_result);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // writes both registers, only while the pool is idle
  task automatic set_config(int unsigned bytes, bit grow);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= fbfl_pkg::REG_BLOCK_BYTES;
    cfg_data <= fbfl_pkg::CFG_DATA_W'(bytes);
    @(posedge clk);
    cfg_index <= fbfl_pkg::REG_AUTO_GROW;
    cfg_data <= {{(fbfl_pkg::CFG_DATA_W-1){1'b0}}, grow};
    @(posedge clk);
    cfg_write <= 1'b0;
    blk_bytes = bytes;
    grow_en = grow;
    @(posedge clk);
  endtask

  function automatic bit field_ok(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // result checker and output stall
  always @(posedge clk) begin
    fbfl_pkg::out_item_t exp_r;
    bit                  ok;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %p", $time, out_data);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          ok = field_ok("status", 16'(exp_r.status), 16'(out_data.status));
          ok &= field_ok("granted_handle", 16'(exp_r.granted_handle),
                         16'(out_data.granted_handle));
          ok &= field_ok("live_count", 16'(exp_r.live_count), 16'(out_data.live_count));
          ok &= field_ok("peak_count", 16'(exp_r.peak_count), 16'(out_data.peak_count));
          ok &= field_ok("pages_in_use", 16'(exp_r.pages_in_use),
                         16'(out_data.pages_in_use));
          if (!ok) errors++;
        end
        stall_left = out_idle ? $urandom_range(13, 0) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  task automatic test_directed();
    set_config(8, 1'b1);
    send_item(make_item(fbfl_pkg::CMD_ALLOC, 8, 0, 0, 0));      // first page on demand
    send_item(make_item(fbfl_pkg::CMD_ALLOC, 9, 0, 0, 0));
    send_item(make_item(fbfl_pkg::CMD_ALLOC, 0, 0, 0, 0));
    send_item(make_item(fbfl_pkg::CMD_FREE, 0, 0, 1, 0));       // null free
    send_item(make_item(fbfl_pkg::CMD_FREE, 0, 1, 128, 0));     // beyond pages in use
    send_item(make_item(fbfl_pkg::CMD_FREE, 0, 1, 1, 0));
    send_item(make_item(fbfl_pkg::CMD_FREE, 0, 1, 1, 0));       // double free
    send_item(make_item(fbfl_pkg::CMD_FREE, 0, 1, 1, 0));       // live stays at zero
    send_item(make_item(fbfl_pkg::CMD_RELEASE, 0, 0, 0, 0));
    send_item(make_item(fbfl_pkg::CMD_PREALLOC, 0, 0, 0, 0));
    send_item(make_item(fbfl_pkg::CMD_PREALLOC, 0, 0, 0, 24'hFFFFFF));
    send_item(make_item(fbfl_pkg::CMD_FREE, 0, 1, 1023, 0));
    send_item(make_item(fbfl_pkg::CMD_ALLOC, 65535, 0, 0, 0));
    send_item(make_item(fbfl_pkg::CMD_ALLOC, 8, 0, 0, 0));
    set_config(65535, 1'b0);
    send_item(make_item(fbfl_pkg::CMD_ALLOC, 65535, 0, 0, 0));
    send_item(make_item(fbfl_pkg::CMD_RELEASE, 0, 0, 0, 0));
    send_item(make_item(fbfl_pkg::CMD_ALLOC, 1, 0, 0, 0));      // no growth allowed
    send_item(make_item(fbfl_pkg::CMD_PREALLOC, 0, 0, 0, BLOCKS * 65535 - 1));
    send_item(make_item(fbfl_pkg::CMD_PREALLOC, 0, 0, 0, BLOCKS * 65535));
    send_item(make_item(fbfl_pkg::CMD_FREE, 0, 1, 383, 0));
    send_item(make_item(fbfl_pkg::CMD_FREE, 0, 1, 384, 0));
    set_config(5, 1'b1);                                         // acts as pointer size
    send_item(make_item(fbfl_pkg::CMD_ALLOC, 8, 0, 0, 0));
    send_item(make_item(fbfl_pkg::CMD_ALLOC, 9, 0, 0, 0));
    send_item(make_item(fbfl_pkg::CMD_RELEASE, 0, 0, 0, 0));
    held_handles.delete();
  endtask

  // mostly allocate/free of handed-out handles, plus noise and page commands
  task automatic test_random_traffic(int count, int unsigned bytes, bit grow,
                                     bit idle_in, bit idle_out);
    fbfl_pkg::in_item_t it;
    int unsigned        sel;
    int unsigned        k;
    int unsigned        page_bytes;
    bit                 from_held;
    set_config(bytes, grow);
    in_idle = idle_in;
    out_idle = idle_out;
    page_bytes = BLOCKS * eff_block_bytes();
    for (int i = 0; i < count; i++) begin
      it = IN_W'({$urandom, $urandom});
      from_held = 1'b0;
      sel = $urandom_range(99, 0);
      if (sel < 45 || (sel < 75 && held_handles.size() == 0)) begin
        it.command = fbfl_pkg::CMD_ALLOC;
        if ($urandom_range(6, 0) != 0)
          it.request_bytes = fbfl_pkg::BYTES_W'($urandom_range(eff_block_bytes(), 0));
      end else if (sel < 75) begin
        it.command = fbfl_pkg::CMD_FREE;
        it.handle_present = 1'b1;
        k = $urandom_range(held_handles.size() - 1, 0);
        it.free_handle = fbfl_pkg::HANDLE_W'(held_handles[k]);
        held_handles.delete(k);
        from_held = 1'b1;
      end else if (sel < 88) begin
        it.command = fbfl_pkg::CMD_FREE;
        // in-range handles here may be double frees
        if (sel < 80 && pages > 0) begin
          it.handle_present = 1'b1;
          it.free_handle = fbfl_pkg::HANDLE_W'($urandom_range(pages * BLOCKS - 1, 0));
        end
      end else if (sel < 92) begin
        it.command = fbfl_pkg::CMD_ALLOC;
      end else if (sel < 97) begin
        it.command = fbfl_pkg::CMD_PREALLOC;
        if ($urandom_range(3, 0) != 0)
          it.prealloc_bytes = ($urandom_range(3 * page_bytes, 0) > 24'hFFFFFF) ?
                              24'hFFFFFF :
                              fbfl_pkg::PRE_W'($urandom_range(3 * page_bytes, 0));
      end else begin
        it.command = fbfl_pkg::CMD_RELEASE;
      end
      send_item(it);
      if (it.command == fbfl_pkg::CMD_ALLOC && last_result.status == fbfl_pkg::STAT_OK)
        held_handles.insert(held_handles.size(), 32'(last_result.granted_handle));
      else if (it.command == fbfl_pkg::CMD_RELEASE)
        held_handles.delete();
      else if (from_held && last_result.status != fbfl_pkg::STAT_OK)
        held_handles.insert(held_handles.size(), 32'(it.free_handle));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(350, 8, 1'b1, 1'b1, 1'b1);
    test_random_traffic(250, 65535, 1'b1, 1'b1, 1'b1);
    test_random_traffic(250, 8, 1'b0, 1'b1, 1'b1);
    test_random_traffic(300, 300, 1'b1, 1'b0, 1'b0);
    test_random_traffic(150, 0, 1'b1, 1'b1, 1'b0);
    test_random_traffic(125, 65535, 1'b0, 1'b0, 1'b1);
    drain();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
src/fbfl_pkg.sv
src/fbfl_ram.sv
src/fbfl_ctrl.sv
src/fbfl_datapath.sv
src/fixed_block_free_list_allocator.sv
bench/fixed_block_free_list_allocator_tb.sv
